// ----- hw/rtl/qmn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_pkg
// Types and fixed widths shared by the normalized quaternion product blocks.
// ----------------------------------------------------------------------------
package qmn_pkg;

    // Signed Hamilton product component: four 32-bit terms summed.
    localparam int PW  = 34;
    // Magnitude of a product component (at most 2^32).
    localparam int MW  = 33;
    // Square of a magnitude (at most 2^64).
    localparam int SQW = 65;
    // Sum of four squares (at most 2^66).
    localparam int SW  = 67;

    localparam logic [31:0] SAT_POS     = 32'd32767;
    localparam logic [31:0] SAT_NEG_MAG = 32'd32768;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
    } qmn_in_t;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
        logic               zero_magnitude;
    } qmn_out_t;

    // Control that travels beside each item between the pipeline sections.
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [3:0] neg;
    } qmn_side_t;

    function automatic logic signed [PW-1:0] sx_term(input logic signed [31:0] v);
        return {{(PW-32){v[31]}}, v};
    endfunction

endpackage

// ----- hw/rtl/quaternion_multiply_normalize.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Hamilton product of two Q2.F quaternions scaled to unit length, Q2.F out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  operand   in         operand_valid / operand_stall  qmn_in_t  (a, b)
//  result    out        result_valid / result_stall    qmn_out_t (r, zero_magnitude)
//
//  One item enters per cycle unless a valid result is held by result_stall.
//  The pipeline is six front stages, then the divider, one quotient bit per
//  stage (2F+3), and the square root, one root bit per stage (F+2).
//  Reset clears the valid bits only; no clearing pass is needed.
//  A stalled result holds the whole pipeline in place, bubbles included.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize #(
    parameter int FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                operand_valid,
    output logic                operand_stall,
    input  qmn_pkg::qmn_in_t    operand,
    output logic                result_valid,
    input  logic                result_stall,
    output qmn_pkg::qmn_out_t   result
);
    import qmn_pkg::*;

    localparam int          NS      = FRAC_BITS + 2;
    localparam logic [31:0] ONE     = 32'd1 << FRAC_BITS;
    localparam logic [15:0] IDENT_W = (ONE > SAT_POS) ? SAT_POS[15:0] : ONE[15:0];

    logic                       en;
    qmn_side_t                  front_side;
    logic [SW-1:0]              sum_sq;
    logic [3:0][SQW-1:0]        mag_sq;
    qmn_side_t                  div_side;
    logic [3:0][2*FRAC_BITS+2:0] quot;
    qmn_side_t                  sqrt_side;
    logic [3:0][NS-1:0]         root;

    logic [NS:0]                inc   [4];
    logic [31:0]                mag32 [4];
    logic [3:0][15:0]           comp;
    qmn_out_t                   result_next;
    qmn_out_t                   result_reg;
    logic                       result_valid_reg;

    assign en            = !(result_valid_reg && result_stall);
    assign operand_stall = !en;

    qmn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .operand_valid (operand_valid),
        .operand       (operand),
        .side          (front_side),
        .sum_sq        (sum_sq),
        .mag_sq        (mag_sq)
    );

    qmn_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (front_side),
        .sum_sq   (sum_sq),
        .mag_sq   (mag_sq),
        .side_out (div_side),
        .quot     (quot)
    );

    qmn_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (div_side),
        .quot     (quot),
        .side_out (sqrt_side),
        .root     (root)
    );

    // The rounded ratio is the largest n with 2n-1 <= root, i.e. (root+1)/2.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            inc[c]   = {1'b0, root[c]} + 1'b1;
            mag32[c] = 32'(inc[c][NS:1]);
            if (sqrt_side.neg[c])
            begin
                comp[c] = (mag32[c] > SAT_NEG_MAG) ? SAT_NEG_MAG[15:0]
                                                   : 16'(32'd0 - mag32[c]);
            end
            else
            begin
                comp[c] = (mag32[c] > SAT_POS) ? SAT_POS[15:0] : mag32[c][15:0];
            end
        end
        if (sqrt_side.zero)
        begin
            result_next = '{r_x: '0, r_y: '0, r_z: '0, r_w: IDENT_W, zero_magnitude: 1'b1};
        end
        else
        begin
            result_next = '{r_x: comp[0], r_y: comp[1], r_z: comp[2], r_w: comp[3],
                            zero_magnitude: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= sqrt_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_magnitude |->
            result.r_x == 16'sd0 && result.r_y == 16'sd0 && result.r_z == 16'sd0)
        else $error("zero product did not give the identity");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.zero_magnitude |->
            $signed(result.r_x) <= $signed({1'b0, IDENT_W}) &&
            $signed(result.r_w) <= $signed({1'b0, IDENT_W}))
        else $error("normalized component above unit magnitude");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        operand_stall |=> $stable(sqrt_side) && $stable(div_side))
        else $error("pipeline moved while the result was stalled");

endmodule

// ----- hw/rtl/qmn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_front
// Six register stages: partial products, Hamilton sums, magnitudes, squares,
// pairwise half sums and the sum of squares.
// ----------------------------------------------------------------------------
module qmn_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                operand_valid,
    input  qmn_pkg::qmn_in_t                    operand,
    output qmn_pkg::qmn_side_t                  side,
    output logic [qmn_pkg::SW-1:0]              sum_sq,
    output logic [3:0][qmn_pkg::SQW-1:0]        mag_sq
);
    import qmn_pkg::*;

    logic [5:0]             valid_reg;

    logic signed [31:0]     prod_next [16];
    logic signed [31:0]     prod_reg  [16];
    logic signed [PW-1:0]   comp_next [4];
    logic signed [PW-1:0]   comp_reg  [4];
    logic [MW-1:0]          mag_next  [4];
    logic [MW-1:0]          mag_reg   [4];
    logic [3:0]             neg_next;
    logic                   zero_next;
    logic [3:0]             neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic                   zero3_reg, zero4_reg, zero5_reg, zero6_reg;
    logic [2*MW-1:0]        sq_full   [4];
    logic [SQW-1:0]         sq4_reg   [4];
    logic [SQW-1:0]         sq5_reg   [4];
    logic [SQW-1:0]         sq6_reg   [4];
    logic [SQW:0]           half_next [2];
    logic [SQW:0]           half_reg  [2];
    logic [SW-1:0]          sum_next;
    logic [SW-1:0]          sum_reg;

    always_comb
    begin
        prod_next[0]  = operand.a_w * operand.b_x;
        prod_next[1]  = operand.a_x * operand.b_w;
        prod_next[2]  = operand.a_y * operand.b_z;
        prod_next[3]  = operand.a_z * operand.b_y;
        prod_next[4]  = operand.a_w * operand.b_y;
        prod_next[5]  = operand.a_x * operand.b_z;
        prod_next[6]  = operand.a_y * operand.b_w;
        prod_next[7]  = operand.a_z * operand.b_x;
        prod_next[8]  = operand.a_w * operand.b_z;
        prod_next[9]  = operand.a_x * operand.b_y;
        prod_next[10] = operand.a_y * operand.b_x;
        prod_next[11] = operand.a_z * operand.b_w;
        prod_next[12] = operand.a_w * operand.b_w;
        prod_next[13] = operand.a_x * operand.b_x;
        prod_next[14] = operand.a_y * operand.b_y;
        prod_next[15] = operand.a_z * operand.b_z;
    end

    always_comb
    begin
        comp_next[0] = sx_term(prod_reg[0]) + sx_term(prod_reg[1])
                     + sx_term(prod_reg[2]) - sx_term(prod_reg[3]);
        comp_next[1] = sx_term(prod_reg[4]) - sx_term(prod_reg[5])
                     + sx_term(prod_reg[6]) + sx_term(prod_reg[7]);
        comp_next[2] = sx_term(prod_reg[8]) + sx_term(prod_reg[9])
                     - sx_term(prod_reg[10]) + sx_term(prod_reg[11]);
        comp_next[3] = sx_term(prod_reg[12]) - sx_term(prod_reg[13])
                     - sx_term(prod_reg[14]) - sx_term(prod_reg[15]);
    end

    always_comb
    begin
        zero_next = 1'b1;
        for (int c = 0; c < 4; c++)
        begin
            neg_next[c] = comp_reg[c][PW-1];
            mag_next[c] = comp_reg[c][PW-1] ? MW'(-comp_reg[c]) : MW'(comp_reg[c]);
            if (comp_reg[c] != '0)
            begin
                zero_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sq_full[c] = mag_reg[c] * mag_reg[c];
        end
        half_next[0] = {1'b0, sq4_reg[0]} + {1'b0, sq4_reg[1]};
        half_next[1] = {1'b0, sq4_reg[2]} + {1'b0, sq4_reg[3]};
        sum_next     = {1'b0, half_reg[0]} + {1'b0, half_reg[1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], operand_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            comp_reg  <= comp_next;
            mag_reg   <= mag_next;
            neg3_reg  <= neg_next;
            zero3_reg <= zero_next;
            for (int c = 0; c < 4; c++)
            begin
                sq4_reg[c] <= sq_full[c][SQW-1:0];
            end
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            half_reg  <= half_next;
            sq5_reg   <= sq4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            sum_reg   <= sum_next;
            sq6_reg   <= sq5_reg;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    assign side   = '{valid: valid_reg[5], zero: zero6_reg, neg: neg6_reg};
    assign sum_sq = sum_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            mag_sq[c] = sq6_reg[c];
        end
    end

endmodule

// ----- hw/rtl/qmn_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_div
// Restoring divider, one quotient bit per stage, four lanes sharing one
// divisor: floor(|p|^2 * 2^(2F+2) / s) for every component.
// ----------------------------------------------------------------------------
module qmn_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  qmn_pkg::qmn_side_t                  side_in,
    input  logic [qmn_pkg::SW-1:0]              sum_sq,
    input  logic [3:0][qmn_pkg::SQW-1:0]        mag_sq,
    output qmn_pkg::qmn_side_t                  side_out,
    output logic [3:0][2*FRAC_BITS+2:0]         quot
);
    import qmn_pkg::*;

    localparam int QW = 2*FRAC_BITS + 3;

    logic                   valid_reg [QW];
    logic                   zero_reg  [QW];
    logic [3:0]             neg_reg   [QW];
    logic [SW-1:0]          den_reg   [QW];
    logic [3:0][SW-1:0]     rem_reg   [QW];
    logic [3:0][QW-1:0]     quo_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic               valid_cur;
        logic               zero_cur;
        logic [3:0]         neg_cur;
        logic [SW-1:0]      den_cur;
        logic [3:0][SW-1:0] rem_cur;
        logic [3:0][QW-1:0] quo_cur;
        logic [3:0]         bit_cur;
        logic [SW:0]        cand [4];
        logic [3:0][SW-1:0] rem_next;
        logic [3:0][QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            // The dividend is the square shifted up by 2F+2, so its upper part
            // is the square halved and only its lowest bit is shifted in here.
            always_comb
            begin
                valid_cur = side_in.valid;
                zero_cur  = side_in.zero;
                neg_cur   = side_in.neg;
                den_cur   = sum_sq;
                quo_cur   = '0;
                for (int c = 0; c < 4; c++)
                begin
                    rem_cur[c] = {{(SW-SQW+1){1'b0}}, mag_sq[c][SQW-1:1]};
                    bit_cur[c] = mag_sq[c][0];
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                valid_cur = valid_reg[k-1];
                zero_cur  = zero_reg[k-1];
                neg_cur   = neg_reg[k-1];
                den_cur   = den_reg[k-1];
                rem_cur   = rem_reg[k-1];
                quo_cur   = quo_reg[k-1];
                bit_cur   = '0;
            end
        end

        always_comb
        begin
            for (int c = 0; c < 4; c++)
            begin
                cand[c] = {rem_cur[c], bit_cur[c]};
                if (cand[c] >= {1'b0, den_cur})
                begin
                    rem_next[c] = SW'(cand[c] - {1'b0, den_cur});
                    quo_next[c] = {quo_cur[c][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = cand[c][SW-1:0];
                    quo_next[c] = {quo_cur[c][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[k] <= zero_cur;
                neg_reg[k]  <= neg_cur;
                den_reg[k]  <= den_cur;
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
            end
        end
    end

    assign side_out = '{valid: valid_reg[QW-1], zero: zero_reg[QW-1], neg: neg_reg[QW-1]};
    assign quot     = quo_reg[QW-1];

endmodule

// ----- hw/rtl/qmn_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_sqrt
// Digit-by-digit integer square root, one root bit per stage, four lanes.
// ----------------------------------------------------------------------------
module qmn_sqrt #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  qmn_pkg::qmn_side_t                  side_in,
    input  logic [3:0][2*FRAC_BITS+2:0]         quot,
    output qmn_pkg::qmn_side_t                  side_out,
    output logic [3:0][FRAC_BITS+1:0]           root
);
    import qmn_pkg::*;

    localparam int NS = FRAC_BITS + 2;
    localparam int XW = 2*NS;

    logic                   valid_reg [NS];
    logic                   zero_reg  [NS];
    logic [3:0]             neg_reg   [NS];
    logic [3:0][XW-1:0]     x_reg     [NS];
    logic [3:0][NS:0]       rem_reg   [NS];
    logic [3:0][NS-1:0]     root_reg  [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        logic               valid_cur;
        logic               zero_cur;
        logic [3:0]         neg_cur;
        logic [3:0][XW-1:0] x_cur;
        logic [3:0][NS:0]   rem_cur;
        logic [3:0][NS-1:0] root_cur;
        logic [NS+2:0]      rem_sh [4];
        logic [NS+2:0]      trial  [4];
        logic [3:0][XW-1:0] x_next;
        logic [3:0][NS:0]   rem_next;
        logic [3:0][NS-1:0] root_next;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                valid_cur = side_in.valid;
                zero_cur  = side_in.zero;
                neg_cur   = side_in.neg;
                rem_cur   = '0;
                root_cur  = '0;
                for (int c = 0; c < 4; c++)
                begin
                    x_cur[c] = {1'b0, quot[c]};
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                valid_cur = valid_reg[j-1];
                zero_cur  = zero_reg[j-1];
                neg_cur   = neg_reg[j-1];
                x_cur     = x_reg[j-1];
                rem_cur   = rem_reg[j-1];
                root_cur  = root_reg[j-1];
            end
        end

        always_comb
        begin
            for (int c = 0; c < 4; c++)
            begin
                rem_sh[c] = {rem_cur[c], x_cur[c][XW-1:XW-2]};
                trial[c]  = {1'b0, root_cur[c], 2'b01};
                x_next[c] = {x_cur[c][XW-3:0], 2'b00};
                if (rem_sh[c] >= trial[c])
                begin
                    rem_next[c]  = (NS+1)'(rem_sh[c] - trial[c]);
                    root_next[c] = {root_cur[c][NS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c]  = rem_sh[c][NS:0];
                    root_next[c] = {root_cur[c][NS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[j] <= zero_cur;
                neg_reg[j]  <= neg_cur;
                x_reg[j]    <= x_next;
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign side_out = '{valid: valid_reg[NS-1], zero: zero_reg[NS-1], neg: neg_reg[NS-1]};
    assign root     = root_reg[NS-1];

endmodule
